### hw/rtl/per_source_replay_guard_table_unit_macros.svh
// Assertion macros shared by the replay guard table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PER_SOURCE_REPLAY_GUARD_TABLE_UNIT_MACROS_SVH
`define PER_SOURCE_REPLAY_GUARD_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSRG_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("psrg: assertion failed");
`define PSRG_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("psrg: forbidden condition seen");
`else
`define PSRG_ASSERT(label, clk, rstn, prop)
`define PSRG_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

### hw/rtl/psrg_pkg.sv
// Package of the replay guard table: slot entry layout, reset constants,
// controller command and status structs. No dependencies.
`default_nettype none
package psrg_pkg;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] session;
        logic [31:0] seq;
        logic [63:0] time_us;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    localparam logic [31:0] RETIRE_RESET = 32'd30000000;
    localparam logic [31:0] SEQ_FRESH    = 32'd1;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } psrg_cmd_t;

    typedef struct packed {
        logic scan_last;
    } psrg_status_t;

endpackage
`default_nettype wire

### hw/rtl/psrg_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module psrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wen,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              ren,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (ren) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/psrg_ctrl.sv
// Controller of the replay guard table: request sequencing and result handshake.
// Depends on psrg_pkg and the assertion macro header.
`default_nettype none
`include "per_source_replay_guard_table_unit_macros.svh"
module psrg_ctrl
    import psrg_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  wire logic   m_ready,
    output psrg_cmd_t   cmd,
    input  wire psrg_status_t status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `PSRG_ASSERT(a_result_from_decide, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_DECIDE))
    `PSRG_ASSERT(a_scan_follows_load, aclk, aresetn, cmd.load |=> (state_reg == ST_SCAN) && !s_ready)

endmodule
`default_nettype wire

### hw/rtl/psrg_datapath.sv
// Datapath of the replay guard table: request registers, slot memory scan,
// match/free/oldest tracking, accept decision and table update.
// Depends on psrg_pkg, psrg_ram and the assertion macro header.
`default_nettype none
`include "per_source_replay_guard_table_unit_macros.svh"
module psrg_datapath
    import psrg_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr,
    input  wire logic [31:0]  cfg_retire_time_us,
    input  wire logic [31:0]  s_source_ident,
    input  wire logic [31:0]  s_session_ident,
    input  wire logic [31:0]  s_seq_number,
    input  wire logic [63:0]  s_receive_time_us,
    output logic              m_accepted,
    input  wire psrg_cmd_t    cmd,
    output psrg_status_t      status
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slot_entry_t      req_reg;
    slot_entry_t      rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic [31:0]      retire_reg;
    logic [SLOTS-1:0] valid_reg, valid_next;

    logic [IDX_W-1:0] scan_cnt_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             chk_en_reg;

    logic             match_hit_reg, match_newer_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_hit_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             old_hit_reg;
    logic [IDX_W-1:0] old_idx_reg;
    logic [63:0]      old_time_reg;
    logic             acc_reg;

    logic             rd_vld, key_eq, newer;
    logic [31:0]      seq_diff;
    logic [64:0]      age;
    logic             dec_ok;
    logic [IDX_W-1:0] target;

    psrg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .aclk (aclk),
        .wen  (cmd.commit && dec_ok),
        .waddr(target),
        .wdata(req_reg),
        .ren  (cmd.step),
        .raddr(scan_cnt_reg),
        .rdata(rd_data)
    );

    assign rd_entry         = slot_entry_t'(rd_data);
    assign rd_vld           = valid_reg[chk_idx_reg];
    assign key_eq           = (rd_entry.source == req_reg.source)
                           && (rd_entry.session == req_reg.session);
    assign seq_diff         = req_reg.seq - rd_entry.seq;
    assign newer            = (seq_diff != 32'd0) && !seq_diff[31];
    assign status.scan_last = (scan_cnt_reg == IDX_W'(SLOTS - 1));
    assign age              = {1'b0, req_reg.time_us} - {1'b0, old_time_reg};
    assign m_accepted       = acc_reg;

    always_comb begin
        dec_ok = 1'b0;
        target = old_idx_reg;
        if (match_hit_reg) begin
            dec_ok = match_newer_reg;
            target = match_idx_reg;
        end else if (free_hit_reg) begin
            dec_ok = 1'b1;
            target = free_idx_reg;
        end else if (old_hit_reg) begin
            dec_ok = (req_reg.seq == SEQ_FRESH) && !age[64]
                  && (age[63:0] >= {32'd0, retire_reg});
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.commit && dec_ok) begin
            valid_next[target] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retire_reg    <= RETIRE_RESET;
            valid_reg     <= '0;
            scan_cnt_reg  <= '0;
            chk_en_reg    <= 1'b0;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            old_hit_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                retire_reg <= cfg_retire_time_us;
            end
            valid_reg  <= valid_next;
            chk_en_reg <= cmd.step;
            if (cmd.load) begin
                scan_cnt_reg  <= '0;
                match_hit_reg <= 1'b0;
                free_hit_reg  <= 1'b0;
                old_hit_reg   <= 1'b0;
            end else begin
                if (cmd.step) begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                end
                if (chk_en_reg) begin
                    if (rd_vld && key_eq && !match_hit_reg) begin
                        match_hit_reg <= 1'b1;
                    end
                    if (!rd_vld && !free_hit_reg) begin
                        free_hit_reg <= 1'b1;
                    end
                    if (rd_vld) begin
                        old_hit_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg.source  <= s_source_ident;
            req_reg.session <= s_session_ident;
            req_reg.seq     <= s_seq_number;
            req_reg.time_us <= s_receive_time_us;
        end
        if (cmd.step) begin
            chk_idx_reg <= scan_cnt_reg;
        end
        if (chk_en_reg) begin
            if (rd_vld && key_eq && !match_hit_reg) begin
                match_idx_reg   <= chk_idx_reg;
                match_newer_reg <= newer;
            end
            if (!rd_vld && !free_hit_reg) begin
                free_idx_reg <= chk_idx_reg;
            end
            if (rd_vld && (!old_hit_reg || (rd_entry.time_us < old_time_reg))) begin
                old_idx_reg  <= chk_idx_reg;
                old_time_reg <= rd_entry.time_us;
            end
        end
        if (cmd.commit) begin
            acc_reg <= dec_ok;
        end
    end

    `PSRG_ASSERT(a_load_clears_scan, aclk, aresetn, cmd.load |=> !match_hit_reg && !free_hit_reg && !old_hit_reg)
    `PSRG_ASSERT_NEVER(a_commit_mid_scan, aclk, aresetn, cmd.commit && (chk_en_reg || cmd.step))
    `PSRG_ASSERT(a_commit_sets_valid, aclk, aresetn, (cmd.commit && dec_ok) |=> valid_reg[$past(target)])

endmodule
`default_nettype wire

### hw/rtl/per_source_replay_guard_table_unit.sv
// Replay guard table, top level: controller, datapath and slot memory.
// Depends on psrg_pkg, psrg_ctrl, psrg_datapath and psrg_ram.
//
// Keeps up to SLOTS (source, session) entries with their last sequence number
// and receive time. Each request is answered with one accepted bit: a known
// pair needs a newer sequence in 32-bit serial arithmetic, an unknown pair
// takes the lowest free slot, and in a full table the least recently seen
// entry is replaced only by a sequence of 1 once it has been idle for at least
// retire_time_us. A request passes through the controller states in order:
// the idle state takes the request, then the slot memory, which has one read
// port, is scanned one entry per cycle, then a wait state ends the last
// compare and a decide state follows. The decide state holds while an earlier
// result still waits. The result sits in an output register, so the next
// request may start while it waits to be taken. Valid bits clear at reset;
// no memory clearing pass is needed. The configuration port is always ready.
`default_nettype none
module per_source_replay_guard_table_unit
    import psrg_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_retire_time_us,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_source_ident,
    input  wire logic [31:0] s_session_ident,
    input  wire logic [31:0] s_seq_number,
    input  wire logic [63:0] s_receive_time_us,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_accepted
);

    psrg_cmd_t    cmd;
    psrg_status_t status;

    assign cfg_ready = 1'b1;

    psrg_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    psrg_datapath #(
        .SLOTS(SLOTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr            (cfg_valid && cfg_ready),
        .cfg_retire_time_us(cfg_retire_time_us),
        .s_source_ident    (s_source_ident),
        .s_session_ident   (s_session_ident),
        .s_seq_number      (s_seq_number),
        .s_receive_time_us (s_receive_time_us),
        .m_accepted        (m_accepted),
        .cmd               (cmd),
        .status            (status)
    );

endmodule
`default_nettype wire
